>>> rtl/two_list_sorted_merge_assert.svh
// Assertion macros for the merge block's top-level RTL file.
`ifndef TWO_LIST_SORTED_MERGE_ASSERT_SVH
`define TWO_LIST_SORTED_MERGE_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, off while reset.
`define TLSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Consequent holds in the cycle after reset is applied.
`define TLSM_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/tlsm_pkg.sv
// Types and constants shared by the merge block's modules.
`default_nettype none
package tlsm_pkg;

   localparam int WORD_W          = 32;
   localparam int CMD_W           = 2;
   localparam int LIST_DEPTH_DEF  = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

   // command codes on the request port
   localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MERGE       = 2'd2;

   // classified operation passed from front to back
   typedef enum logic [1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_MERGE       = 2'd2
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [WORD_W-1:0] value;
   } q_item_type;

endpackage
`default_nettype wire

>>> rtl/tlsm_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
`default_nettype none
module tlsm_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [tlsm_pkg::CMD_W-1:0]        req_command,
   input  wire logic signed [tlsm_pkg::WORD_W-1:0] req_value,
   output logic                                   q_valid,
   input  wire logic                              q_take,
   output tlsm_pkg::q_item_type                   q_item
);
   import tlsm_pkg::*;

   q_item_type                q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]      fill_ff, fill_in;
   logic                      cmd_known;
   op_type                    cmd_op;
   logic                      do_push;
   logic                      do_take;

   // classify the command; unused codes are dropped here
   always_comb begin
      cmd_known = 1'b1;
      cmd_op    = OP_MERGE;
      case (req_command)
         CMD_LOAD_FIRST:  cmd_op = OP_LOAD_FIRST;
         CMD_LOAD_SECOND: cmd_op = OP_LOAD_SECOND;
         CMD_MERGE:       cmd_op = OP_MERGE;
         default:         cmd_known = 1'b0;
      endcase
   end

   assign req_full = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_valid  = (fill_ff != '0);
   assign q_item   = q_mem_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full && cmd_known;
   assign do_take  = q_take && q_valid;

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_take) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_take) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= '{op: cmd_op, value: req_value};
      end
   end

endmodule
`default_nettype wire

>>> rtl/tlsm_back.sv
// Back end: list memories, merge sequencer and result register.
`default_nettype none
module tlsm_back #(
   parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   output logic                                    q_take,
   input  wire tlsm_pkg::q_item_type               q_item,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic signed [tlsm_pkg::WORD_W-1:0]      rsp_value_res,
   output logic                                    rsp_last
);
   import tlsm_pkg::*;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int REM_W = $clog2(2 * LIST_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]          ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0]  out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;
   logic signed [WORD_W-1:0]  head_a_ff, head_b_ff;
   logic signed [WORD_W-1:0]  mem_a [LIST_DEPTH];
   logic signed [WORD_W-1:0]  mem_b [LIST_DEPTH];
   logic                      wr_a, wr_b;
   logic                      out_free, a_done, b_done, pick_a;

   assign out_free = !out_valid_ff || rsp_pop;
   assign a_done   = (ptr_a_ff >= cnt_a_ff);
   assign b_done   = (ptr_b_ff >= cnt_b_ff);
   // second list wins on equal heads
   assign pick_a   = !a_done && (b_done || (head_a_ff < head_b_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      q_take       = 1'b0;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               case (q_item.op)
                  OP_LOAD_FIRST: begin
                     if (cnt_a_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (cnt_b_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end
                  end
                  OP_MERGE: begin
                     rem_in = REM_W'(cnt_a_ff) + REM_W'(cnt_b_ff);
                     if (rem_in != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // one word out per cycle while the result register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = pick_a ? head_a_ff : head_b_ff;
               out_last_in  = (rem_ff == REM_W'(1));
               rem_in       = rem_ff - 1'b1;
               if (pick_a) begin
                  ptr_a_in = ptr_a_ff + 1'b1;
               end else begin
                  ptr_b_in = ptr_b_ff + 1'b1;
               end
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ptr_a_in = '0;
                  ptr_b_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   // list memories: one write, one registered read each; read follows next pointer
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[IDX_W-1:0]] <= q_item.value;
      end
      head_a_ff <= mem_a[ptr_a_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[cnt_b_ff[IDX_W-1:0]] <= q_item.value;
      end
      head_b_ff <= mem_b[ptr_b_in[IDX_W-1:0]];
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_value_res = out_value_ff;
   assign rsp_last      = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/two_list_sorted_merge.sv
// Top level: two-way merge of two sorted lists of signed words.
// The back end takes queued items only while idle; the front queue holds up to four items.
// A merge of N stored words gives N results, one per cycle while the result register is
// free; the pace is held back only when a held result is not popped.
// Reset empties the queue, both lists and the result register; list contents stay as they are.
`default_nettype none
`include "two_list_sorted_merge_assert.svh"
module two_list_sorted_merge #(
   parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [tlsm_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [tlsm_pkg::WORD_W-1:0] req_value,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic signed [tlsm_pkg::WORD_W-1:0]      rsp_value_res,
   output logic                                    rsp_last
);
   import tlsm_pkg::*;

   logic       q_valid;
   logic       q_take;
   q_item_type q_item;

   tlsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_value   (req_value),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_item      (q_item)
   );

   tlsm_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_take        (q_take),
      .q_item        (q_item),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_value_res (rsp_value_res),
      .rsp_last      (rsp_last)
   );

   // a merge run streams without gaps until its last word
   `TLSM_ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_pop && !rsp_empty && !rsp_last, !rsp_empty)
   // nothing follows the last word in the next cycle
   `TLSM_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_pop && !rsp_empty && rsp_last, rsp_empty)
   // reset leaves the result side empty and the input queue open
   `TLSM_ASSERT_AFTER_RESET(a_reset_clean, clock, reset, rsp_empty && !req_full)

endmodule
`default_nettype wire
